// File: hw/rtl/sesd_pkg.sv
// Package for the song event stream decoder: result kinds, decoder phases,
// lead codes and the result record type. No dependencies.
`default_nettype none

package sesd_pkg;

  // Default width of the stream byte counter.
  localparam int unsigned OffsetBitsDef = 24;

  // Widths of the result fields.
  localparam int unsigned DelayW = 24;
  localparam int unsigned LoopW  = 24;
  localparam int unsigned DurW   = 14;
  localparam int unsigned WheelW = 15;

  // Upper nibble of the lead bytes, and the full loop marker byte.
  localparam logic [3:0] LeadNoteOff  = 4'h8;
  localparam logic [3:0] LeadNoteOn   = 4'h9;
  localparam logic [3:0] LeadNoteOnce = 4'hA;
  localparam logic [3:0] LeadWheel    = 4'hE;
  localparam logic [7:0] LoopMarker   = 8'hF0;

  typedef enum logic [2:0] {
    KIND_DELAY     = 3'd0,
    KIND_NOTE_OFF  = 3'd1,
    KIND_NOTE_ON   = 3'd2,
    KIND_NOTE_ONCE = 3'd3,
    KIND_WHEEL     = 3'd4,
    KIND_LOOP      = 3'd5,
    KIND_END       = 3'd6,
    KIND_ERROR     = 3'd7
  } kind_e;

  // What the decoder expects next.
  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_DATA1 = 2'd1,
    PH_DATA2 = 2'd2,
    PH_DATA3 = 2'd3
  } phase_e;

  typedef struct packed {
    kind_e              kind;
    logic [3:0]         channel;
    logic [7:0]         note;
    logic [7:0]         velocity;
    logic [DurW-1:0]    duration_ms;
    logic [WheelW-1:0]  wheel_value;
    logic [DelayW-1:0]  delay_ms;
    logic [LoopW-1:0]   loop_offset;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/song_event_stream_decoder.sv
// Song event stream decoder: one byte per transaction in, decoded result
// records out. Uses sesd_pkg for kinds, phases and the result record.
//
// Output: results are registered into the result queue when the byte that
//   causes them is accepted; the output port shows the queue head.
// Throughput: one byte per cycle while the result queue has room for two
//   results. A byte causes zero, one or two results; results leave at one
//   per cycle from a four-entry result queue while out_ready_i is high, so
//   bytes that cause two results back to back stall the input.
// Reset: rst_ni clears the phase, the held lead and data bytes, the delay
//   sum, the byte counter, the error hold and the result queue.
`default_nettype none

module song_event_stream_decoder #(
  parameter int unsigned OFFSET_BITS = sesd_pkg::OffsetBitsDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // byte input channel
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire  [7:0]                 event_byte_i,
  input  wire                        is_last_i,
  // result output channel
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic [2:0]                 kind_o,
  output logic [3:0]                 channel_o,
  output logic [7:0]                 note_o,
  output logic [7:0]                 velocity_o,
  output logic [sesd_pkg::DurW-1:0]  duration_ms_o,
  output logic [sesd_pkg::WheelW-1:0] wheel_value_o,
  output logic [sesd_pkg::DelayW-1:0] delay_ms_o,
  output logic [sesd_pkg::LoopW-1:0]  loop_offset_o,
  output logic                       last_o
);

  // Result queue: four entries, two pointers and a fill count.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // ---------------------------------------------------------------------
  // Decoder state
  // ---------------------------------------------------------------------
  sesd_pkg::phase_e                phase_q, phase_d;
  logic [7:0]                      held_lead_q, held_lead_d;
  logic [7:0]                      data_first_q, data_first_d;
  logic [7:0]                      data_second_q, data_second_d;
  logic [sesd_pkg::DelayW-1:0]     delay_sum_q, delay_sum_d;
  logic [OFFSET_BITS-1:0]          byte_offset_q, byte_offset_d;
  logic                            error_hold_q, error_hold_d;

  // Queue state
  sesd_pkg::result_t               queue_q [QDepth];
  logic [QPtrW-1:0]                wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]                rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]                count_q, count_d;

  logic                            in_accept;
  logic                            out_accept;

  // Room for the worst case of two results keeps the input side free of
  // any dependence on the output handshake in the same cycle.
  assign in_ready_o  = (count_q <= QCntW'(QDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign in_accept   = in_valid_i & in_ready_o;
  assign out_accept  = out_valid_o & out_ready_i;

  // ---------------------------------------------------------------------
  // Per-byte arithmetic
  // ---------------------------------------------------------------------
  logic [OFFSET_BITS-1:0]          off_next;
  logic [sesd_pkg::LoopW-1:0]      off_out;
  logic [12:0]                     delay_add;
  logic [sesd_pkg::DelayW:0]       sum_wide;
  logic [sesd_pkg::DelayW-1:0]     sum_sat;
  logic                            lead_ok;

  // Counter wraps at its own width; the port shows its low bits.
  assign off_next = byte_offset_q + 1'b1;
  assign off_out  = sesd_pkg::LoopW'(off_next);

  // Short delays count verbatim, long delays count in 64 ms steps.
  assign delay_add = event_byte_i[6]
                   ? {({1'b0, event_byte_i[5:0]} + 7'd1), 6'd0}
                   : {7'd0, event_byte_i[5:0]};
  assign sum_wide  = {1'b0, delay_sum_q} + (sesd_pkg::DelayW + 1)'(delay_add);
  assign sum_sat   = sum_wide[sesd_pkg::DelayW] ? '1 : sum_wide[sesd_pkg::DelayW-1:0];

  assign lead_ok = (event_byte_i[7:4] == sesd_pkg::LeadNoteOff)
                || (event_byte_i[7:4] == sesd_pkg::LeadNoteOn)
                || (event_byte_i[7:4] == sesd_pkg::LeadNoteOnce)
                || (event_byte_i[7:4] == sesd_pkg::LeadWheel);

  // Build the record of a completed channel event.
  function automatic sesd_pkg::result_t event_result(
    input logic [7:0] lead,
    input logic [7:0] first,
    input logic [7:0] second,
    input logic [7:0] final_byte
  );
    sesd_pkg::result_t r;
    r         = '0;
    r.channel = lead[3:0];
    unique case (lead[7:4])
      sesd_pkg::LeadNoteOff: begin
        r.kind     = sesd_pkg::KIND_NOTE_OFF;
        r.note     = first;
        r.velocity = final_byte;
      end
      sesd_pkg::LeadNoteOn: begin
        r.kind     = sesd_pkg::KIND_NOTE_ON;
        r.note     = first;
        r.velocity = final_byte;
      end
      sesd_pkg::LeadNoteOnce: begin
        // unpack: note in a[7:1], velocity a[0]:b[7:2], duration b[1:0]:c times 16
        r.kind        = sesd_pkg::KIND_NOTE_ONCE;
        r.note        = {1'b0, first[7:1]};
        r.velocity    = {1'b0, first[0], second[7:2]};
        r.duration_ms = {second[1:0], final_byte, 4'd0};
      end
      default: begin
        r.kind        = sesd_pkg::KIND_WHEEL;
        r.wheel_value = {final_byte, 7'd0} | {7'd0, first};
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result decode: slot A carries a delay or a completed event, slot B an
  // end, loop or error marker. Either may be absent.
  // ---------------------------------------------------------------------
  sesd_pkg::result_t res_a, res_b;
  logic              va, vb, err;
  logic [3:0]        err_ch;
  sesd_pkg::result_t push0, push1;

  always_comb begin
    res_a  = '0;
    res_b  = '0;
    va     = 1'b0;
    vb     = 1'b0;
    err    = 1'b0;
    err_ch = held_lead_q[3:0];
    if (!error_hold_q) begin
      unique case (phase_q)
        sesd_pkg::PH_LEAD: begin
          err_ch = event_byte_i[3:0];
          if (!event_byte_i[7]) begin
            // delay byte: report the sum only at stream end
            if (is_last_i) begin
              va                = (sum_sat != '0);
              res_a.kind        = sesd_pkg::KIND_DELAY;
              res_a.delay_ms    = sum_sat;
              vb                = 1'b1;
              res_b.kind        = sesd_pkg::KIND_END;
              res_b.loop_offset = off_out;
            end
          end else begin
            // any lead flushes the pending delay first
            va             = (delay_sum_q != '0);
            res_a.kind     = sesd_pkg::KIND_DELAY;
            res_a.delay_ms = delay_sum_q;
            if (lead_ok) begin
              err = is_last_i;
            end else if (event_byte_i == sesd_pkg::LoopMarker) begin
              vb                = 1'b1;
              res_b.kind        = is_last_i ? sesd_pkg::KIND_END : sesd_pkg::KIND_LOOP;
              res_b.loop_offset = off_out;
            end else begin
              err = 1'b1;
            end
          end
        end
        sesd_pkg::PH_DATA1: begin
          err = is_last_i;
        end
        sesd_pkg::PH_DATA2: begin
          if (held_lead_q[7:4] == sesd_pkg::LeadNoteOnce) begin
            err = is_last_i;
          end else begin
            va                = 1'b1;
            res_a             = event_result(held_lead_q, data_first_q, data_second_q,
                                             event_byte_i);
            vb                = is_last_i;
            res_b.kind        = sesd_pkg::KIND_END;
            res_b.loop_offset = off_out;
          end
        end
        sesd_pkg::PH_DATA3: begin
          va                = 1'b1;
          res_a             = event_result(held_lead_q, data_first_q, data_second_q,
                                           event_byte_i);
          vb                = is_last_i;
          res_b.kind        = sesd_pkg::KIND_END;
          res_b.loop_offset = off_out;
        end
        default: ;
      endcase
    end
    if (err) begin
      vb                = 1'b1;
      res_b             = '0;
      res_b.kind        = sesd_pkg::KIND_ERROR;
      res_b.channel     = err_ch;
      res_b.loop_offset = off_out;
    end
    // mark the final result of this byte
    if (vb) begin
      res_b.last = 1'b1;
    end else begin
      res_a.last = 1'b1;
    end
    // pack into queue order
    push0 = va ? res_a : res_b;
    push1 = res_b;
  end

  // ---------------------------------------------------------------------
  // Decoder next state
  // ---------------------------------------------------------------------
  always_comb begin
    phase_d       = phase_q;
    held_lead_d   = held_lead_q;
    data_first_d  = data_first_q;
    data_second_d = data_second_q;
    delay_sum_d   = delay_sum_q;
    byte_offset_d = byte_offset_q;
    error_hold_d  = error_hold_q;
    if (in_accept) begin
      byte_offset_d = off_next;
      if (!error_hold_q) begin
        unique case (phase_q)
          sesd_pkg::PH_LEAD: begin
            if (!event_byte_i[7]) begin
              delay_sum_d = sum_sat;
            end else begin
              delay_sum_d = '0;
              if (lead_ok) begin
                held_lead_d = event_byte_i;
                phase_d     = sesd_pkg::PH_DATA1;
              end else if (event_byte_i != sesd_pkg::LoopMarker) begin
                held_lead_d = event_byte_i;
              end
            end
          end
          sesd_pkg::PH_DATA1: begin
            data_first_d = event_byte_i;
            phase_d      = sesd_pkg::PH_DATA2;
          end
          sesd_pkg::PH_DATA2: begin
            if (held_lead_q[7:4] == sesd_pkg::LeadNoteOnce) begin
              data_second_d = event_byte_i;
              phase_d       = sesd_pkg::PH_DATA3;
            end else begin
              phase_d = sesd_pkg::PH_LEAD;
            end
          end
          sesd_pkg::PH_DATA3: begin
            phase_d = sesd_pkg::PH_LEAD;
          end
          default: ;
        endcase
        if (err) begin
          error_hold_d = 1'b1;
        end
      end
      // stream end rearms the decoder
      if (is_last_i) begin
        phase_d       = sesd_pkg::PH_LEAD;
        held_lead_d   = '0;
        data_first_d  = '0;
        data_second_d = '0;
        delay_sum_d   = '0;
        byte_offset_d = '0;
        error_hold_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= sesd_pkg::PH_LEAD;
      held_lead_q   <= '0;
      data_first_q  <= '0;
      data_second_q <= '0;
      delay_sum_q   <= '0;
      byte_offset_q <= '0;
      error_hold_q  <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      held_lead_q   <= held_lead_d;
      data_first_q  <= data_first_d;
      data_second_q <= data_second_d;
      delay_sum_q   <= delay_sum_d;
      byte_offset_q <= byte_offset_d;
      error_hold_q  <= error_hold_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  logic             push_one, push_two;
  logic [QCntW-1:0] n_push;

  assign push_one = in_accept & (va | vb);
  assign push_two = in_accept & va & vb;
  assign n_push   = push_two ? QCntW'(2) : (push_one ? QCntW'(1) : QCntW'(0));

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(n_push);
    rd_ptr_d = out_accept ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + n_push - QCntW'(out_accept);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold payload in the queue entries; no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_one) begin
      queue_q[wr_ptr_q] <= push0;
    end
    if (push_two) begin
      queue_q[wr_ptr_q + 1'b1] <= push1;
    end
  end

  sesd_pkg::result_t head;
  assign head = queue_q[rd_ptr_q];

  assign kind_o        = head.kind;
  assign channel_o     = head.channel;
  assign note_o        = head.note;
  assign velocity_o    = head.velocity;
  assign duration_ms_o = head.duration_ms;
  assign wheel_value_o = head.wheel_value;
  assign delay_ms_o    = head.delay_ms;
  assign loop_offset_o = head.loop_offset;
  assign last_o        = head.last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("result queue over its depth");

  a_err_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_hold_q |-> (phase_q == sesd_pkg::PH_LEAD) && (delay_sum_q == '0))
    else $error("error hold with event or delay pending");

  a_delay_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (delay_sum_q != '0) |-> (phase_q == sesd_pkg::PH_LEAD))
    else $error("delay pending inside an event");

  a_data3_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == sesd_pkg::PH_DATA3) |-> (held_lead_q[7:4] == sesd_pkg::LeadNoteOnce))
    else $error("third data byte expected for a non-once lead");

  a_end_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_last_i) |=> (byte_offset_q == '0) && !error_hold_q
                                 && (phase_q == sesd_pkg::PH_LEAD))
    else $error("decoder not rearmed after stream end");

endmodule

`default_nettype wire
